// ----- rtl/core/tga_rle_pixel_decoder_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the Targa pixel decoder
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGA_RLE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be seen.
`define TGA_RLE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ----- rtl/core/tga_rle_pkg.sv -----
// ---------------------------------------------------------------------------
// tga_rle_pkg
// Types and constants shared by the Targa pixel decoder files.
// ---------------------------------------------------------------------------
package tga_rle_pkg;

	localparam int unsigned MAX_DIMENSION_BITS_DEFAULT = 16;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 3;

	// Register indexes of the write port.
	localparam logic [CFG_INDEX_W-1:0] REG_RUN_LENGTH_CODED  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HAS_ALPHA_CHANNEL = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TOP_DOWN_ORDER    = 3'd4;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// Byte lanes of a colour: B, G, R, then A at 32 bpp.
	localparam logic [1:0] PHASE_BLUE  = 2'd0;
	localparam logic [1:0] PHASE_GREEN = 2'd1;
	localparam logic [1:0] PHASE_RED   = 2'd2;
	localparam logic [1:0] PHASE_ALPHA = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel_argb;
		logic [15:0] memory_row;
		logic [15:0] start_column;
		logic [7:0]  run_length;
		logic        image_done;
		logic        alpha_seen;
	} pix_item_t;

	typedef struct packed {
		logic        run_length_coded;
		logic        has_alpha_channel;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        top_down_order;
		logic        restart;
	} cfg_t;

endpackage

// ----- rtl/core/tga_rle_stream_if.sv -----
// ---------------------------------------------------------------------------
// tga_rle_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
interface tga_rle_stream_if #(
	parameter type payload_t = logic [7:0]
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/core/tga_rle_cfg.sv -----
// ---------------------------------------------------------------------------
// tga_rle_cfg
// Configuration registers; a write to a known index requests a restart.
// ---------------------------------------------------------------------------
module tga_rle_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  write_enable,
	input  logic [tga_rle_pkg::CFG_INDEX_W-1:0]   reg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0]    write_data,
	output tga_rle_pkg::cfg_t                     cfg
);

	logic        run_length_coded_q;
	logic        has_alpha_channel_q;
	logic [15:0] image_width_q;
	logic [15:0] image_height_q;
	logic        top_down_order_q;
	logic        restart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_coded_q  <= 1'b0;
			has_alpha_channel_q <= 1'b0;
			image_width_q       <= 16'd1;
			image_height_q      <= 16'd1;
			top_down_order_q    <= 1'b0;
			restart_q           <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (write_enable) begin
				unique case (reg_index)
					tga_rle_pkg::REG_RUN_LENGTH_CODED: begin
						run_length_coded_q <= write_data[0];
						restart_q          <= 1'b1;
					end
					tga_rle_pkg::REG_HAS_ALPHA_CHANNEL: begin
						has_alpha_channel_q <= write_data[0];
						restart_q           <= 1'b1;
					end
					tga_rle_pkg::REG_IMAGE_WIDTH: begin
						image_width_q <= write_data;
						restart_q     <= 1'b1;
					end
					tga_rle_pkg::REG_IMAGE_HEIGHT: begin
						image_height_q <= write_data;
						restart_q      <= 1'b1;
					end
					tga_rle_pkg::REG_TOP_DOWN_ORDER: begin
						top_down_order_q <= write_data[0];
						restart_q        <= 1'b1;
					end
					default: begin
						// Writes beyond the register list are dropped.
					end
				endcase
			end
		end
	end

	assign cfg.run_length_coded  = run_length_coded_q;
	assign cfg.has_alpha_channel = has_alpha_channel_q;
	assign cfg.image_width       = image_width_q;
	assign cfg.image_height      = image_height_q;
	assign cfg.top_down_order    = top_down_order_q;
	assign cfg.restart           = restart_q;

endmodule

// ----- rtl/core/tga_rle_core.sv -----
// ---------------------------------------------------------------------------
// tga_rle_core
// Decode state and the single-byte step: packet headers, colour assembly,
// run clipping, row and column tracking and the result fields.
// ---------------------------------------------------------------------------
module tga_rle_core #(
	parameter int unsigned MAX_DIMENSION_BITS = tga_rle_pkg::MAX_DIMENSION_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tga_rle_pkg::cfg_t      cfg,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	output logic                   emit,
	output tga_rle_pkg::pix_item_t result
);

	localparam int unsigned DW = MAX_DIMENSION_BITS;

	logic          expect_header_q;
	logic          run_packet_q;
	logic [7:0]    remaining_q;
	logic [1:0]    phase_q;
	logic [23:0]   colour_q;
	logic [DW-1:0] col_q;
	logic [DW-1:0] row_q;
	logic          alpha_flag_q;

	logic          expect_header_d;
	logic          run_packet_d;
	logic [7:0]    remaining_d;
	logic [1:0]    phase_d;
	logic [23:0]   colour_d;
	logic [DW-1:0] col_d;
	logic [DW-1:0] row_d;
	logic          alpha_flag_d;

	logic [DW-1:0] w_eff;
	logic [DW-1:0] h_eff;
	logic          finished;
	logic          is_header;
	logic [23:0]   colour_next;
	logic [7:0]    alpha;
	logic          last_byte;
	logic [7:0]    count;
	logic [DW-1:0] room;
	logic [DW-1:0] len;
	logic          may_emit;
	logic [DW:0]   col_sum;
	logic [DW-1:0] col_after;
	logic [DW-1:0] row_last;
	logic [DW-1:0] mrow;
	logic [7:0]    rem_dec;
	logic          row_full;

	always_comb begin
		w_eff = (cfg.image_width[DW-1:0] == '0) ? DW'(1) : cfg.image_width[DW-1:0];
		h_eff = (cfg.image_height[DW-1:0] == '0) ? DW'(1) : cfg.image_height[DW-1:0];
		finished  = (row_q >= h_eff);
		is_header = cfg.run_length_coded && expect_header_q;
		row_last  = h_eff - DW'(1);

		unique case (phase_q)
			tga_rle_pkg::PHASE_BLUE:  colour_next = {16'd0, data_byte};
			tga_rle_pkg::PHASE_GREEN: colour_next = colour_q | {8'd0, data_byte, 8'd0};
			tga_rle_pkg::PHASE_RED:   colour_next = colour_q | {data_byte, 16'd0};
			default:                  colour_next = colour_q;
		endcase
		alpha = (phase_q == tga_rle_pkg::PHASE_ALPHA) ? data_byte : tga_rle_pkg::ALPHA_OPAQUE;
		last_byte = cfg.has_alpha_channel ? (phase_q == tga_rle_pkg::PHASE_ALPHA)
		                                  : (phase_q >= tga_rle_pkg::PHASE_RED);

		count = (remaining_q == 8'd0) ? 8'd1 : remaining_q;
		room  = w_eff - col_q;
		if (cfg.run_length_coded && run_packet_q)
			len = (DW'(count) < room) ? DW'(count) : room;
		else
			len = DW'(1);
		may_emit  = !(cfg.run_length_coded && !run_packet_q) || (col_q < w_eff);
		col_sum   = {1'b0, col_q} + {1'b0, len};
		col_after = may_emit ? col_sum[DW-1:0] : col_q;
		row_full  = (col_after >= w_eff);
		mrow      = cfg.top_down_order ? row_q : (row_last - row_q);
		rem_dec   = (remaining_q != 8'd0) ? (remaining_q - 8'd1) : 8'd0;

		emit = step && !finished && !is_header && last_byte && may_emit;

		result.pixel_argb   = {alpha, colour_next};
		result.memory_row   = 16'(mrow);
		result.start_column = 16'(col_q);
		result.run_length   = 8'(len);
		result.image_done   = (col_sum == {1'b0, w_eff}) && (row_q == row_last);
		result.alpha_seen   = alpha_flag_q || (alpha != tga_rle_pkg::ALPHA_OPAQUE);

		expect_header_d = expect_header_q;
		run_packet_d    = run_packet_q;
		remaining_d     = remaining_q;
		phase_d         = phase_q;
		colour_d        = colour_q;
		col_d           = col_q;
		row_d           = row_q;
		alpha_flag_d    = alpha_flag_q;

		if (step && !finished) begin
			if (is_header) begin
				run_packet_d    = data_byte[7];
				remaining_d     = {1'b0, data_byte[6:0]} + 8'd1;
				expect_header_d = 1'b0;
				phase_d         = tga_rle_pkg::PHASE_BLUE;
			end else if (!last_byte) begin
				colour_d = colour_next;
				phase_d  = phase_q + 2'd1;
			end else begin
				colour_d     = colour_next;
				phase_d      = tga_rle_pkg::PHASE_BLUE;
				col_d        = col_after;
				alpha_flag_d = may_emit ? result.alpha_seen : alpha_flag_q;
				if (!cfg.run_length_coded || run_packet_q) begin
					if (cfg.run_length_coded) begin
						remaining_d     = 8'd0;
						expect_header_d = 1'b1;
					end
					if (row_full) begin
						col_d = '0;
						row_d = row_q + DW'(1);
					end
				end else begin
					remaining_d = rem_dec;
					if (rem_dec == 8'd0) begin
						expect_header_d = 1'b1;
						if (row_full) begin
							col_d = '0;
							row_d = row_q + DW'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b0;
			run_packet_q    <= 1'b0;
			remaining_q     <= 8'd0;
			phase_q         <= tga_rle_pkg::PHASE_BLUE;
			colour_q        <= 24'd0;
			col_q           <= '0;
			row_q           <= '0;
			alpha_flag_q    <= 1'b0;
		end else if (cfg.restart) begin
			expect_header_q <= cfg.run_length_coded;
			run_packet_q    <= 1'b0;
			remaining_q     <= 8'd0;
			phase_q         <= tga_rle_pkg::PHASE_BLUE;
			colour_q        <= 24'd0;
			col_q           <= '0;
			row_q           <= '0;
			alpha_flag_q    <= 1'b0;
		end else begin
			expect_header_q <= expect_header_d;
			run_packet_q    <= run_packet_d;
			remaining_q     <= remaining_d;
			phase_q         <= phase_d;
			colour_q        <= colour_d;
			col_q           <= col_d;
			row_q           <= row_d;
			alpha_flag_q    <= alpha_flag_d;
		end
	end

endmodule

// ----- rtl/core/tga_rle_pixel_decoder.sv -----
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decodes the pixel-data bytes of a true-colour Targa image, raw or
// run-length coded, into runs of ARGB pixels, each with its row and start column.
//
// Usage: bytes arrive on byte_stream, one per transfer, and results leave on
// pixel_stream, one per completed pixel or repeat packet. Header bytes and
// the leading colour bytes of a pixel produce no result. The registers are
// written through write_enable, reg_index and write_data while the block is
// idle; any write to a known register restarts decoding from the first row.
// A transferred byte waits in the input register and is decoded from there;
// the result it completes is loaded into the result register and shown on
// pixel_stream. Throughput is one byte per cycle while the receiver does not
// stall, set by the single input register and the single result register
// around the decode step.
// When the receiver stalls, the finished result stays in the result
// register and the block still holds one further byte in its input
// register; after that byte_stream.ready drops until the result is taken.
// Reset clears both registers and the decode state and selects raw 24 bpp,
// a one by one image, stored bottom-up.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
	parameter int unsigned MAX_DIMENSION_BITS = tga_rle_pkg::MAX_DIMENSION_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tga_rle_stream_if.sink                       byte_stream,
	tga_rle_stream_if.source                     pixel_stream,
	input  logic                                 write_enable,
	input  logic [tga_rle_pkg::CFG_INDEX_W-1:0]  reg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0]   write_data
);

	tga_rle_pkg::cfg_t      cfg;
	tga_rle_pkg::pix_item_t result;
	tga_rle_pkg::pix_item_t out_q;
	logic                   emit;
	logic                   out_valid_q;
	logic                   byte_valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance;
	logic                   byte_take;

	// The byte in the input register is decoded once the result register is
	// free, or is being emptied in this very cycle.
	assign advance   = byte_valid_s1 && (!out_valid_q || pixel_stream.ready);
	assign byte_take = byte_stream.valid && byte_stream.ready;

	assign byte_stream.ready    = !byte_valid_s1 || advance;
	assign pixel_stream.valid   = out_valid_q;
	assign pixel_stream.payload = out_q;

	tga_rle_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.cfg          (cfg)
	);

	tga_rle_core #(
		.MAX_DIMENSION_BITS (MAX_DIMENSION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.data_byte (byte_s1),
		.emit      (emit),
		.result    (result)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_take) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			byte_s1 <= byte_stream.payload.data_byte;
		end
	end

	// Result register: loaded by a decode step that completes a result,
	// emptied by a transfer on pixel_stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (pixel_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

endmodule

// ----- rtl/core/tga_rle_checker.sv -----
// ---------------------------------------------------------------------------
// tga_rle_checker
// Port-level checks on the results of the Targa pixel decoder.
// ---------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   write_enable,
	input logic                   out_valid,
	input logic                   out_ready,
	input tga_rle_pkg::pix_item_t out_item
);

	logic seen_q;
	logic done_q;

	// Track, since the last register write, whether a transferred result has
	// reported a non-opaque alpha, and whether the image has completed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			done_q <= 1'b0;
		end else if (write_enable) begin
			seen_q <= 1'b0;
			done_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			seen_q <= seen_q || out_item.alpha_seen;
			done_q <= done_q || out_item.image_done;
		end
	end

	`TGA_RLE_ASSERT_IMPLIES(a_run_length_range, clk, arst_n, out_valid,
		(out_item.run_length != 8'd0) && (out_item.run_length <= 8'd128),
		"run length outside 1 to 128")
	`TGA_RLE_ASSERT_IMPLIES(a_alpha_reported, clk, arst_n,
		out_valid && (out_item.pixel_argb[31:24] != tga_rle_pkg::ALPHA_OPAQUE),
		out_item.alpha_seen, "non-opaque pixel without alpha_seen")
	`TGA_RLE_ASSERT_IMPLIES(a_alpha_sticky, clk, arst_n, out_valid && seen_q,
		out_item.alpha_seen, "alpha_seen dropped within one image")
	`TGA_RLE_ASSERT_NEVER(a_quiet_after_done, clk, arst_n, done_q && out_valid,
		"result offered after the image completed")

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_tga_rle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.write_enable (write_enable),
	.out_valid    (pixel_stream.valid),
	.out_ready    (pixel_stream.ready),
	.out_item     (pixel_stream.payload)
);

// ----- verif/tb_tga_rle_pixel_decoder.sv -----
// ---------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder
// Self-checking bench for the Targa pixel decoder. A byte source and a pixel
// sink, each with random pauses, surround the block. Every byte transfer is
// fed to a behavioural decoder kept here. That decoder queues the pixel runs
// due, and each pixel transfer is compared field by field with the oldest
// of them. Short hand-made images come first, then many random images under
// changing register settings.
// ---------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	// Bytes of random image data to send after the hand-made images.
	localparam int unsigned RANDOM_ITEMS = 1250;
	// A byte is decoded at the edge after its transfer, so a few quiet
	// cycles are enough for header and colour bytes still inside the block.
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned CYCLE_LIMIT   = 500_000;
	localparam int unsigned LONGEST_PAUSE = 14;
	// Register index with nothing behind it; a write there must be ignored.
	localparam logic [tga_rle_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                                reg_we   = 1'b0;
	logic [tga_rle_pkg::CFG_INDEX_W-1:0] reg_idx  = '0;
	logic [tga_rle_pkg::CFG_DATA_W-1:0]  reg_data = '0;

	logic                  byte_valid   = 1'b0;
	tga_rle_pkg::in_item_t byte_payload = '0;
	logic                  pix_ready    = 1'b0;

	tga_rle_stream_if #(.payload_t(tga_rle_pkg::in_item_t))  byte_if ();
	tga_rle_stream_if #(.payload_t(tga_rle_pkg::pix_item_t)) pix_if ();

	assign byte_if.valid   = byte_valid;
	assign byte_if.payload = byte_payload;
	assign pix_if.ready    = pix_ready;

	tga_rle_pixel_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_stream  (byte_if),
		.pixel_stream (pix_if),
		.write_enable (reg_we),
		.reg_index    (reg_idx),
		.write_data   (reg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Behavioural decoder: register copies and decode state.
	// -----------------------------------------------------------------------
	logic        cfg_coded    = 1'b0;
	logic        cfg_alpha    = 1'b0;
	logic [15:0] cfg_width    = 16'd1;
	logic [15:0] cfg_height   = 16'd1;
	logic        cfg_top_down = 1'b0;

	logic        want_header   = 1'b0;
	logic        repeat_packet = 1'b0;
	int unsigned packet_left   = 0;
	logic [1:0]  lane          = tga_rle_pkg::PHASE_BLUE;
	logic [23:0] colour_acc    = '0;
	int unsigned col_pos       = 0;
	int unsigned row_pos       = 0;
	logic        alpha_latch   = 1'b0;

	// Pixel runs that the block still owes, oldest first.
	tga_rle_pkg::pix_item_t pending_pixels[$];
	// Bytes waiting for the source to present them.
	tga_rle_pkg::in_item_t  byte_backlog[$];

	int unsigned mismatches      = 0;
	int unsigned bytes_accepted  = 0;
	int unsigned results_checked = 0;
	int unsigned images_finished = 0;
	int unsigned settings_used   = 0;
	int unsigned stream_bytes    = 0;
	int unsigned cycle_count     = 0;

	// A width or height of zero behaves as one.
	function automatic int unsigned dim_or_one(input logic [15:0] v);
		return (v == 16'd0) ? 1 : v;
	endfunction

	task automatic restart_decode();
		want_header   = cfg_coded;
		repeat_packet = 1'b0;
		packet_left   = 0;
		lane          = tga_rle_pkg::PHASE_BLUE;
		colour_acc    = '0;
		col_pos       = 0;
		row_pos       = 0;
		alpha_latch   = 1'b0;
	endtask

	// Queues one run starting at the current column and moves past it.
	task automatic emit_run(input logic [31:0] argb, input int unsigned len,
			input int unsigned w, input int unsigned h);
		tga_rle_pkg::pix_item_t want;
		int unsigned            mrow;
		mrow = cfg_top_down ? row_pos : h - 1 - row_pos;
		if (argb[31:24] != tga_rle_pkg::ALPHA_OPAQUE)
			alpha_latch = 1'b1;
		want.pixel_argb   = argb;
		want.memory_row   = 16'(mrow);
		want.start_column = 16'(col_pos);
		want.run_length   = 8'(len);
		want.image_done   = (col_pos + len == w) && (row_pos == h - 1);
		want.alpha_seen   = alpha_latch;
		pending_pixels.push_back(want);
		col_pos += len;
	endtask

	task automatic next_row();
		col_pos = 0;
		row_pos = row_pos + 1;
	endtask

	// Works out what one accepted byte does to the decode state.
	task automatic decode_byte(input logic [7:0] b);
		int unsigned w, h, bpp, count, room, len;
		logic [7:0]  alpha;
		logic [31:0] argb;
		w   = dim_or_one(cfg_width);
		h   = dim_or_one(cfg_height);
		bpp = cfg_alpha ? 4 : 3;
		// Once the last row is complete, everything else is dropped.
		if (row_pos >= h)
			return;
		if (cfg_coded && want_header) begin
			repeat_packet = b[7];
			packet_left   = b[6:0] + 1;
			want_header   = 1'b0;
			lane          = tga_rle_pkg::PHASE_BLUE;
			return;
		end
		if (lane == tga_rle_pkg::PHASE_BLUE)
			colour_acc = {16'h0000, b};
		else if (lane != tga_rle_pkg::PHASE_ALPHA)
			colour_acc[8*lane +: 8] = b;
		alpha = (lane == tga_rle_pkg::PHASE_ALPHA) ? b : tga_rle_pkg::ALPHA_OPAQUE;
		if (lane + 1 < bpp) begin
			lane = lane + 2'd1;
			return;
		end
		lane = tga_rle_pkg::PHASE_BLUE;
		argb = {alpha, colour_acc};
		if (!cfg_coded) begin
			emit_run(argb, 1, w, h);
			if (col_pos >= w)
				next_row();
		end else if (repeat_packet) begin
			// A repeat run is clipped at the row end.
			count = (packet_left == 0) ? 1 : packet_left;
			room  = w - col_pos;
			len   = (count < room) ? count : room;
			emit_run(argb, len, w, h);
			packet_left = 0;
			want_header = 1'b1;
			if (col_pos >= w)
				next_row();
		end else begin
			// Literal pixels past the row end are swallowed silently, and
			// the row only moves on when the packet is finished.
			if (col_pos < w)
				emit_run(argb, 1, w, h);
			if (packet_left > 0)
				packet_left--;
			if (packet_left == 0) begin
				want_header = 1'b1;
				if (col_pos >= w)
					next_row();
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Register writes. Only called while nothing is in flight, so the
	// decoder copy can be updated at once without racing a transfer.
	// -----------------------------------------------------------------------
	task automatic write_reg(input logic [tga_rle_pkg::CFG_INDEX_W-1:0] idx,
			input logic [tga_rle_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		reg_we   <= 1'b1;
		reg_idx  <= idx;
		reg_data <= data;
		case (idx)
			tga_rle_pkg::REG_RUN_LENGTH_CODED:  cfg_coded    = data[0];
			tga_rle_pkg::REG_HAS_ALPHA_CHANNEL: cfg_alpha    = data[0];
			tga_rle_pkg::REG_IMAGE_WIDTH:       cfg_width    = data;
			tga_rle_pkg::REG_IMAGE_HEIGHT:      cfg_height   = data;
			tga_rle_pkg::REG_TOP_DOWN_ORDER:    cfg_top_down = data[0];
			default:                            return;
		endcase
		restart_decode();
	endtask

	// Writes all five registers, starting at a random one, on consecutive
	// cycles. The one-bit registers get random upper data bits.
	task automatic apply_settings(input logic coded, input logic alpha,
			input logic [15:0] w, input logic [15:0] h, input logic top);
		logic [tga_rle_pkg::CFG_INDEX_W-1:0] reg_order [5];
		logic [tga_rle_pkg::CFG_DATA_W-1:0]  data;
		int unsigned                         first;
		reg_order = '{tga_rle_pkg::REG_RUN_LENGTH_CODED, tga_rle_pkg::REG_HAS_ALPHA_CHANNEL,
			tga_rle_pkg::REG_IMAGE_WIDTH, tga_rle_pkg::REG_IMAGE_HEIGHT,
			tga_rle_pkg::REG_TOP_DOWN_ORDER};
		first = $urandom_range(0, 4);
		for (int k = 0; k < 5; k++) begin
			case (reg_order[(first + k) % 5])
				tga_rle_pkg::REG_RUN_LENGTH_CODED:  data = {15'($urandom), coded};
				tga_rle_pkg::REG_HAS_ALPHA_CHANNEL: data = {15'($urandom), alpha};
				tga_rle_pkg::REG_IMAGE_WIDTH:       data = w;
				tga_rle_pkg::REG_IMAGE_HEIGHT:      data = h;
				default:                            data = {15'($urandom), top};
			endcase
			write_reg(reg_order[(first + k) % 5], data);
		end
		@(posedge clk);
		reg_we <= 1'b0;
		settings_used++;
	endtask

	// -----------------------------------------------------------------------
	// Stimulus building.
	// -----------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b, input bit counted);
		tga_rle_pkg::in_item_t item;
		item.data_byte = b;
		byte_backlog.push_back(item);
		if (counted)
			stream_bytes++;
	endtask

	// One colour: B, G, R and, at 32 bpp, an alpha that is mostly opaque.
	task automatic push_pixel();
		push_byte(8'($urandom), 1'b1);
		push_byte(8'($urandom), 1'b1);
		push_byte(8'($urandom), 1'b1);
		if (cfg_alpha)
			push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom)
				: tga_rle_pkg::ALPHA_OPAQUE, 1'b1);
	endtask

	// Packet length: mostly short and inside the row, sometimes filling it,
	// sometimes running past its end.
	function automatic int unsigned draw_count(input int unsigned room);
		int unsigned cap;
		cap = (room < 128) ? room : 128;
		case ($urandom_range(0, 9))
			0:       return $urandom_range(1, 128);
			1:       return cap;
			default: return $urandom_range(1, (cap < 6) ? cap : 6);
		endcase
	endfunction

	// Builds a well-formed image for the current settings, row by row, until
	// it is complete or the byte budget runs out. A stray byte now and then
	// knocks the packet framing out of step. A few bytes follow the image.
	task automatic build_image(input int unsigned budget);
		int unsigned w, h, row, col, room, count, start;
		w     = dim_or_one(cfg_width);
		h     = dim_or_one(cfg_height);
		start = stream_bytes;
		for (row = 0; row < h && stream_bytes - start < budget; row++) begin
			col = 0;
			while (col < w && stream_bytes - start < budget) begin
				room = w - col;
				if ($urandom_range(0, 99) == 0)
					repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b1);
				if (!cfg_coded) begin
					push_pixel();
					col++;
				end else begin
					count = draw_count(room);
					if ($urandom_range(0, 1) == 1) begin
						push_byte({1'b1, 7'(count - 1)}, 1'b1);
						push_pixel();
					end else begin
						push_byte({1'b0, 7'(count - 1)}, 1'b1);
						repeat (count) push_pixel();
					end
					col += (count < room) ? count : room;
				end
			end
		end
		repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
	endtask

	// Returns once every byte has been transferred, every run has come
	// back, and the block has had time to finish bytes that owe nothing.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (byte_backlog.size() != 0 || byte_valid || pending_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Pause before the next item. Each side drifts in and out of stretches
	// where it never pauses at all.
	function automatic int unsigned draw_pause(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, LONGEST_PAUSE);
	endfunction

	// -----------------------------------------------------------------------
	// Byte source. A byte is presented after its pause and held until the
	// transfer; the decoder copy sees it at that same edge.
	// -----------------------------------------------------------------------
	bit          source_busy = 1'b0;
	bit          source_calm = 1'b0;
	int unsigned source_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid   <= 1'b0;
			byte_payload <= '0;
			source_busy = 1'b0;
			source_wait = 0;
		end else begin
			if (byte_valid && byte_if.ready) begin
				decode_byte(byte_payload.data_byte);
				bytes_accepted++;
				source_busy = 1'b0;
				source_wait = draw_pause(source_calm);
			end
			if (!source_busy) begin
				if (source_wait != 0) begin
					source_wait--;
				end else if (byte_backlog.size() != 0) begin
					byte_payload <= byte_backlog.pop_front();
					source_busy = 1'b1;
				end
			end
			byte_valid <= source_busy;
		end
	end

	// -----------------------------------------------------------------------
	// Pixel sink. Each accepted run is checked against the oldest one owed;
	// ready then drops for a random pause, which can be empty.
	// -----------------------------------------------------------------------
	bit                     sink_calm = 1'b0;
	int unsigned            sink_hold = 0;
	tga_rle_pkg::pix_item_t run_seen;
	tga_rle_pkg::pix_item_t run_owed;

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ready <= 1'b0;
			sink_hold = 0;
		end else begin
			if (pix_if.valid && pix_ready) begin
				run_seen = pix_if.payload;
				results_checked++;
				if (run_seen.image_done === 1'b1)
					images_finished++;
				if (pending_pixels.size() == 0) begin
					$error("pixel run with none owed: argb 'h%0h row %0d column %0d",
						run_seen.pixel_argb, run_seen.memory_row, run_seen.start_column);
					mismatches++;
				end else begin
					run_owed = pending_pixels.pop_front();
					compare_field("pixel_argb", run_owed.pixel_argb, run_seen.pixel_argb);
					compare_field("memory_row", 32'(run_owed.memory_row),
						32'(run_seen.memory_row));
					compare_field("start_column", 32'(run_owed.start_column),
						32'(run_seen.start_column));
					compare_field("run_length", 32'(run_owed.run_length),
						32'(run_seen.run_length));
					compare_field("image_done", 32'(run_owed.image_done),
						32'(run_seen.image_done));
					compare_field("alpha_seen", 32'(run_owed.alpha_seen),
						32'(run_seen.alpha_seen));
				end
				sink_hold = draw_pause(sink_calm);
			end else if (sink_hold != 0) begin
				sink_hold--;
			end
			pix_ready <= (sink_hold == 0);
		end
	end

	// Guard against a hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d runs still owed", cycle_count,
				pending_pixels.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Test sequence.
	// -----------------------------------------------------------------------
	initial begin : stimulus
		int unsigned random_start;
		int unsigned phase_no;
		int unsigned budget;
		logic        coded, alpha, top;
		logic [15:0] w, h;

		restart_decode();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Settings out of reset: raw, 24 bpp, one pixel, bottom-up. One
		// pixel with extreme colour bytes fills the image; the bytes after
		// it must be ignored.
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hFE, 1'b0);
		wait_idle();

		// Coded, 32 bpp, three by two, top-down. First row: a repeat of two
		// with a transparent colour, then a literal of two of which only the
		// first fits.
		apply_settings(1'b1, 1'b1, 16'd3, 16'd2, 1'b1);
		@(negedge clk);
		push_byte(8'h81, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h20, 1'b0);
		push_byte(8'h30, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h40, 1'b0);
		push_byte(8'h50, 1'b0);
		push_byte(8'h60, 1'b0);
		push_byte(8'h80, 1'b0);
		wait_idle();

		// A write to an unmapped index must not restart decoding.
		write_reg(REG_UNMAPPED, '1);
		@(posedge clk);
		reg_we <= 1'b0;
		@(negedge clk);

		// Second row: a repeat of the full 128, clipped to the three columns.
		push_byte(8'hFF, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h03, 1'b0);
		push_byte(8'hFF, 1'b0);

		// Random images. The first few settings hit the register extremes,
		// including a zero width and a zero height.
		random_start = stream_bytes;
		for (phase_no = 0; stream_bytes - random_start < RANDOM_ITEMS; phase_no++) begin
			wait_idle();
			budget = 150;
			case (phase_no)
				0: begin
					coded = 1'b0; alpha = 1'b0; w = 16'd0; h = 16'd3; top = 1'b0;
				end
				1: begin
					coded = 1'b1; alpha = 1'b1; w = 16'hFFFF; h = 16'hFFFF; top = 1'b0;
				end
				2: begin
					coded = 1'b1; alpha = 1'b0; w = 16'd5; h = 16'd0; top = 1'b1;
				end
				3: begin
					coded = 1'b0; alpha = 1'b1; w = 16'hFFFF; h = 16'd1; top = 1'b1;
				end
				4: begin
					coded = 1'b1; alpha = 1'b1; w = 16'd128; h = 16'd1; top = 1'b1;
				end
				default: begin
					coded  = ($urandom_range(0, 3) != 0);
					alpha  = 1'($urandom);
					top    = 1'($urandom);
					w      = ($urandom_range(0, 6) != 0) ? 16'($urandom_range(1, 12))
						: 16'($urandom_range(13, 200));
					h      = 16'($urandom_range(1, 6));
					budget = $urandom_range(40, 160);
				end
			endcase
			apply_settings(coded, alpha, w, h, top);
			@(negedge clk);
			build_image(budget);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d bytes through %0d register settings; %0d pixel runs checked,",
			bytes_accepted, settings_used, results_checked);
		$display("%0d images completed, %0d mismatches", images_finished, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
